FILE: design/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU pipeline.
// No dependencies; front, divider, back and top use it by scoped names.
package fpa_pkg;

    localparam int FracBitsDefault = 8;
    localparam int WordBits        = 32;
    localparam int ProdBits        = 64;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_COMPARE  = 4'd4,
        CMD_MIN      = 4'd5,
        CMD_MAX      = 4'd6,
        CMD_INC      = 4'd7,
        CMD_DEC      = 4'd8,
        CMD_FROM_INT = 4'd9,
        CMD_TO_INT   = 4'd10
    } cmd_t;

    // Per-item control and early results carried alongside the divider.
    typedef struct packed {
        logic [3:0]                 cmd;
        logic signed [WordBits-1:0] val;
        logic                       lt;
        logic                       eq;
        logic                       gt;
        logic                       ovf;
        logic                       dz;
        logic                       neg;
        logic signed [ProdBits-1:0] prod;
    } side_t;

endpackage

FILE: design/fpa_front.sv
// Entry stage of the fixed-point ALU: decode, simple operations, multiplier
// and divider operand setup. Depends on fpa_pkg.
module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::FracBitsDefault,
    parameter int NW        = 32 + FRAC_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [3:0]             in_cmd,
    input  logic signed [31:0]     in_a,
    input  logic signed [31:0]     in_b,
    output logic                   valid_reg,
    output fpa_pkg::side_t         side_reg,
    output logic [NW-1:0]          num_reg,
    output logic [31:0]            den_reg
);

    fpa_pkg::side_t     side_next;
    logic [31:0]        ma;
    logic [31:0]        mb;
    logic signed [32:0] sum33;
    logic signed [32:0] dif33;
    logic signed [32:0] inc33;
    logic signed [32:0] dec33;
    logic signed [63:0] shl64;

    localparam logic signed [63:0] Max64 = 64'sd2147483647;
    localparam logic signed [63:0] Min64 = -64'sd2147483648;

    assign ma    = in_a[31] ? 32'(-in_a) : 32'(in_a);
    assign mb    = in_b[31] ? 32'(-in_b) : 32'(in_b);
    assign sum33 = 33'(in_a) + 33'(in_b);
    assign dif33 = 33'(in_a) - 33'(in_b);
    assign inc33 = 33'(in_a) + 33'sd1;
    assign dec33 = 33'(in_a) - 33'sd1;
    assign shl64 = 64'(in_a) <<< FRAC_BITS;

    // Saturate a 33-bit sum to the 32-bit range.
    function automatic logic [32:0] sat33(input logic signed [32:0] v);
        logic [32:0] r;
        if (v[32] != v[31]) begin
            r = {1'b1, v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    always_comb begin
        side_next      = '0;
        side_next.cmd  = in_cmd;
        side_next.neg  = in_a[31] ^ in_b[31];
        side_next.prod = 64'(in_a) * 64'(in_b);
        unique case (fpa_pkg::cmd_t'(in_cmd))
            fpa_pkg::CMD_ADD: begin
                {side_next.ovf, side_next.val} = sat33(sum33);
            end
            fpa_pkg::CMD_SUB: begin
                {side_next.ovf, side_next.val} = sat33(dif33);
            end
            fpa_pkg::CMD_INC: begin
                {side_next.ovf, side_next.val} = sat33(inc33);
            end
            fpa_pkg::CMD_DEC: begin
                {side_next.ovf, side_next.val} = sat33(dec33);
            end
            fpa_pkg::CMD_DIV: begin
                side_next.dz = (in_b == 32'sd0);
            end
            fpa_pkg::CMD_COMPARE: begin
                side_next.lt = in_a < in_b;
                side_next.eq = in_a == in_b;
                side_next.gt = in_a > in_b;
            end
            fpa_pkg::CMD_MIN: begin
                side_next.val = (in_a < in_b) ? in_a : in_b;
            end
            fpa_pkg::CMD_MAX: begin
                side_next.val = (in_a > in_b) ? in_a : in_b;
            end
            fpa_pkg::CMD_FROM_INT: begin
                if (shl64 > Max64) begin
                    side_next.val = 32'sh7FFF_FFFF;
                    side_next.ovf = 1'b1;
                end else if (shl64 < Min64) begin
                    side_next.val = 32'sh8000_0000;
                    side_next.ovf = 1'b1;
                end else begin
                    side_next.val = shl64[31:0];
                end
            end
            fpa_pkg::CMD_TO_INT: begin
                side_next.val = in_a >>> FRAC_BITS;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            num_reg  <= NW'(ma) << FRAC_BITS;
            den_reg  <= mb;
        end
    end

endmodule

FILE: design/fpa_div_stage.sv
// One restoring-division stage: retires one quotient bit per item.
// Depends on fpa_pkg for the side-band struct.
module fpa_div_stage #(
    parameter int NW = 40
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  fpa_pkg::side_t in_side,
    input  logic [31:0]    in_rem,
    input  logic [NW-1:0]  in_num,
    input  logic [NW-1:0]  in_quo,
    input  logic [31:0]    in_den,
    output logic           valid_reg,
    output fpa_pkg::side_t side_reg,
    output logic [31:0]    rem_reg,
    output logic [NW-1:0]  num_reg,
    output logic [NW-1:0]  quo_reg,
    output logic [31:0]    den_reg
);

    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] rem_next;

    assign trial    = {in_rem, in_num[NW-1]};
    assign ge       = trial >= {1'b0, in_den};
    assign diff     = trial - {1'b0, in_den};
    assign rem_next = ge ? diff[31:0] : trial[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            rem_reg  <= rem_next;
            num_reg  <= in_num << 1;
            quo_reg  <= {in_quo[NW-2:0], ge};
            den_reg  <= in_den;
        end
    end

endmodule

FILE: design/fpa_back.sv
// Final stage: product and quotient rounding, saturation, result register.
// Depends on fpa_pkg.
module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::FracBitsDefault,
    parameter int NW        = 32 + FRAC_BITS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  fpa_pkg::side_t in_side,
    input  logic [31:0]    in_rem,
    input  logic [NW-1:0]  in_quo,
    input  logic [31:0]    in_den,
    output logic           valid_reg,
    output logic [39:0]    data_reg
);

    localparam logic [63:0] Half    = 64'd1 << (FRAC_BITS - 1);
    localparam logic [63:0] PosLim  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NegLim  = 64'h0000_0000_8000_0000;

    logic [63:0]        pmag;
    logic [63:0]        mag;
    logic [63:0]        qmag;
    logic               neg;
    logic               ovf;
    logic signed [31:0] val;
    logic [39:0]        data_next;

    assign pmag = in_side.prod[63] ? 64'(-in_side.prod) : 64'(in_side.prod);
    assign qmag = 64'(in_quo) + 64'({in_rem, 1'b0} >= {1'b0, in_den});

    always_comb begin
        mag = '0;
        neg = 1'b0;
        val = in_side.val;
        ovf = in_side.ovf;
        if (fpa_pkg::cmd_t'(in_side.cmd) == fpa_pkg::CMD_MUL ||
            (fpa_pkg::cmd_t'(in_side.cmd) == fpa_pkg::CMD_DIV && !in_side.dz)) begin
            if (fpa_pkg::cmd_t'(in_side.cmd) == fpa_pkg::CMD_MUL) begin
                mag = (pmag + Half) >> FRAC_BITS;
                neg = in_side.prod[63];
            end else begin
                mag = qmag;
                neg = in_side.neg;
            end
            if (!neg && mag > PosLim) begin
                val = 32'sh7FFF_FFFF;
                ovf = 1'b1;
            end else if (neg && mag > NegLim) begin
                val = 32'sh8000_0000;
                ovf = 1'b1;
            end else begin
                val = neg ? 32'(-mag) : mag[31:0];
            end
        end
        data_next = {3'b000, in_side.dz, ovf, in_side.gt, in_side.eq, in_side.lt, val};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: design/fixed_point_alu_q24_8_top.sv
// Top level of the signed Q24.8 fixed-point ALU pipeline.
// Depends on fpa_pkg, fpa_front, fpa_div_stage and fpa_back.
//
// Usage:
//   Requests enter on the s_ stream: s_tuser carries the command code,
//   s_tdata carries operand_a (low word) and operand_b (high word).
//   Results leave on the m_ stream: m_tdata carries the value and flags.
// Pipeline: FRAC_BITS + 34 registers lie between the input and m_tvalid
//   (one entry stage, 32 + FRAC_BITS divider stages, one result stage).
//   Every operation takes the same path so results stay in request order.
// Throughput: one request per cycle unless stalled; the bit-serial divider
//   is unrolled into one stage per quotient bit, so it never blocks a new request.
// Reset: aresetn low clears all valid bits; in-flight requests are dropped
//   and m_tvalid goes low on the next cycle.
// Stall: while m_tvalid is high and m_tready low, the whole pipeline holds
//   and s_tready is low; nothing is lost or repeated. Bubbles advance freely
//   while the output register is empty.
module fixed_point_alu_q24_8_top #(
    parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [3:0]  s_tuser,   // [3:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] value, [32] less, [33] equal,
                                   // [34] greater, [35] overflow,
                                   // [36] divide_by_zero, [39:37] zero
);

    localparam int NW = 32 + FRAC_BITS;

    logic           en;
    logic           v_s    [0:NW];
    fpa_pkg::side_t side_s [0:NW];
    logic [31:0]    rem_s  [0:NW];
    logic [NW-1:0]  num_s  [0:NW];
    logic [NW-1:0]  quo_s  [0:NW];
    logic [31:0]    den_s  [0:NW];

    // Advance everything whenever the output register is free or draining.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    fpa_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tuser),
        .in_a      (s_tdata[31:0]),
        .in_b      (s_tdata[63:32]),
        .valid_reg (v_s[0]),
        .side_reg  (side_s[0]),
        .num_reg   (num_s[0]),
        .den_reg   (den_s[0])
    );

    // Divider starts from a clear remainder and quotient.
    assign rem_s[0] = '0;
    assign quo_s[0] = '0;

    for (genvar i = 0; i < NW; i++) begin : g_div
        fpa_div_stage #(.NW(NW)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v_s[i]),
            .in_side   (side_s[i]),
            .in_rem    (rem_s[i]),
            .in_num    (num_s[i]),
            .in_quo    (quo_s[i]),
            .in_den    (den_s[i]),
            .valid_reg (v_s[i+1]),
            .side_reg  (side_s[i+1]),
            .rem_reg   (rem_s[i+1]),
            .num_reg   (num_s[i+1]),
            .quo_reg   (quo_s[i+1]),
            .den_reg   (den_s[i+1])
        );
    end

    // Round, saturate and hold the result until the sink takes it.
    fpa_back #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_s[NW]),
        .in_side   (side_s[NW]),
        .in_rem    (rem_s[NW]),
        .in_quo    (quo_s[NW]),
        .in_den    (den_s[NW]),
        .valid_reg (m_tvalid),
        .data_reg  (m_tdata)
    );

    // num_s at the last stage is fully shifted out and unused downstream.
    logic unused_num;
    assign unused_num = ^num_s[NW];

endmodule

FILE: design/fpa_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
// Depends on fixed_point_alu_q24_8_top ports only.
module fpa_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    a_compare_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[34:32]))
        else $error("conflicting compare flags");

    a_div_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[36] |-> m_tdata[31:0] == 32'd0 && !m_tdata[35])
        else $error("divide by zero result not clean");

endmodule

bind fixed_point_alu_q24_8_top fpa_port_checker u_fpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
